@@ hw/rtl/lpht_pkg.sv @@
// Shared constants, types and codes for the linear-probing hash table.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int PAYLOAD_BITS = 16;
    localparam int KEY_W        = 32;
    localparam int PLD_W        = 16;
    localparam int SLOT_OUT_W   = 8;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAYLOAD_BITS-1:0] slot_pld_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        key_t      key;
        slot_pld_t payload;
    } slot_entry_t;

    typedef struct packed {
        logic en;
        idx_t addr;
    } slot_rd_t;

    typedef struct packed {
        logic        en;
        idx_t        addr;
        slot_entry_t entry;
    } slot_wr_t;

    typedef struct packed {
        logic        valid;
        slot_entry_t entry;
    } slot_data_t;

endpackage

@@ hw/rtl/lpht_ifs.sv @@
// Request and response channel interfaces of the hash table.
// Depends on lpht_pkg for field widths.
`timescale 1ns / 1ps

interface lpht_req_if
    import lpht_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic [PLD_W-1:0]        payload;

    modport source (output valid, output req_type, output key, output payload, input ready);
    modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

interface lpht_rsp_if
    import lpht_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [PLD_W-1:0]      found_payload;
    logic [SLOT_OUT_W-1:0] slot_index;

    modport source (output valid, output status, output found_payload, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input found_payload, input slot_index,
                    output ready);
endinterface

@@ hw/rtl/lpht_store.sv @@
// Slot store: key/payload RAM with registered read, plus per-slot valid flags.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_store
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_rd_t   rd,
    input  slot_wr_t   wr,
    output slot_data_t rd_data
);

    slot_entry_t              slot_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   slot_valid_reg;
    logic                     rd_valid_reg;
    slot_entry_t              rd_entry_reg;

    // Key/payload RAM: no reset, contents only read behind a set valid flag
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_mem[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_entry_reg <= slot_mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                slot_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= slot_valid_reg[rd.addr];
            end
        end
    end

    assign rd_data.valid = rd_valid_reg;
    assign rd_data.entry = rd_entry_reg;

endmodule

@@ hw/rtl/linear_probe_hash_table.sv @@
// Top level of the linear-probing hash table: probe sequencer and response register.
// Depends on lpht_pkg, lpht_ifs and lpht_store.
//
//   port  | dir | transaction carries
//   ------+-----+------------------------------------------
//   req   | in  | req_type, key, payload (insert or lookup)
//   rsp   | out | status, found_payload, slot_index
//
// A request probes P slots (1 up to TABLE_DEPTH), one slot per cycle through the single
// RAM read port, before its response is registered.
// req.ready is high only while no request is being probed.
// Reset clears every valid flag at once; no clearing pass is needed.
// A stalled response holds the probe at its final slot; the next request is still taken
// while the last response waits on rsp.ready.
`timescale 1ns / 1ps

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lpht_req_if.sink  req,
    lpht_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t                state_reg, state_next;
    logic                  type_reg, type_next;
    key_t                  key_reg, key_next;
    logic [PLD_W-1:0]      pld_reg, pld_next;
    idx_t                  idx_reg, idx_next;
    idx_t                  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [PLD_W-1:0]      out_pld_reg, out_pld_next;
    logic [SLOT_OUT_W-1:0] out_idx_reg, out_idx_next;

    slot_rd_t   rd;
    slot_wr_t   wr;
    slot_data_t rd_data;

    logic    out_free;
    logic    last_probe;
    logic    key_match;
    logic    done;
    status_t result;

    lpht_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign last_probe = (cnt_reg == '1);
    assign key_match  = (rd_data.entry.key == key_reg);

    always_comb
    begin
        done   = 1'b0;
        result = ST_NOT_FOUND;
        if (type_reg == REQ_INSERT)
        begin
            if (!rd_data.valid)
            begin
                done   = 1'b1;
                result = ST_INSERTED;
            end
            else if (last_probe)
            begin
                done   = 1'b1;
                result = ST_FULL;
            end
        end
        else
        begin
            if (!rd_data.valid)
            begin
                done   = 1'b1;
                result = ST_NOT_FOUND;
            end
            else if (key_match)
            begin
                done   = 1'b1;
                result = ST_FOUND;
            end
            else if (last_probe)
            begin
                done   = 1'b1;
                result = ST_NOT_FOUND;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        key_next        = key_reg;
        pld_next        = pld_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pld_next    = out_pld_reg;
        out_idx_next    = out_idx_reg;
        rd              = '0;
        wr              = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    key_next   = req.key;
                    pld_next   = req.payload;
                    idx_next   = req.key[IDX_W-1:0];
                    cnt_next   = '0;
                    rd.en      = 1'b1;
                    rd.addr    = req.key[IDX_W-1:0];
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (done)
                begin
                    // hold on the final slot until the response register frees up
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = result;
                        out_pld_next    = '0;
                        out_idx_next    = '0;
                        if (result == ST_INSERTED)
                        begin
                            wr.en            = 1'b1;
                            wr.addr          = idx_reg;
                            wr.entry.key     = key_reg;
                            wr.entry.payload = PAYLOAD_BITS'(pld_reg);
                            out_idx_next     = SLOT_OUT_W'(idx_reg);
                        end
                        else if (result == ST_FOUND)
                        begin
                            out_pld_next = PLD_W'(rd_data.entry.payload);
                            out_idx_next = SLOT_OUT_W'(idx_reg);
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // advance to the next slot, wrapping at the end of the table
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    rd.en    = 1'b1;
                    rd.addr  = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            type_reg       <= REQ_INSERT;
            key_reg        <= '0;
            pld_reg        <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_pld_reg    <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            type_reg       <= type_next;
            key_reg        <= key_next;
            pld_reg        <= pld_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pld_reg    <= out_pld_next;
            out_idx_reg    <= out_idx_next;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_payload = out_pld_reg;
    assign rsp.slot_index    = out_idx_reg;

endmodule

@@ hw/rtl/lpht_checker.sv @@
// Port-level assertions for the hash table, bound onto the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps

module lpht_port_checker
    import lpht_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [1:0]            rsp_status,
    input logic [PLD_W-1:0]      rsp_found_payload,
    input logic [SLOT_OUT_W-1:0] rsp_slot_index
);

    // a response that is not taken stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request at a time: ready drops after every accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a probe is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_FOUND) |-> (rsp_found_payload == '0))
        else $error("payload returned without a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
            |-> (rsp_slot_index == '0))
        else $error("slot index returned without a slot");

endmodule

bind linear_probe_hash_table lpht_port_checker u_lpht_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_found_payload (rsp.found_payload),
    .rsp_slot_index    (rsp.slot_index)
);

@@ bench/lpht_checker.sv @@
// Scoreboard for the hash table: watches both channels, keeps its own copy of the table
// and compares every response with the answer it predicts. Depends on lpht_pkg and lpht_ifs.
`timescale 1ns / 1ps

module lpht_checker
    import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lpht_req_if  req,
    lpht_rsp_if  rsp,
    output int   n_fail,
    output int   n_pending,
    output int   n_hits,
    output int   n_full
);

    typedef struct packed {
        status_t               status;
        logic [PLD_W-1:0]      pld;
        logic [SLOT_OUT_W-1:0] slot;
    } answer_t;

    bit        slot_used [TABLE_DEPTH];
    key_t      slot_keys [TABLE_DEPTH];
    slot_pld_t slot_plds [TABLE_DEPTH];
    answer_t   answers_due [$];

    // Walk the table as the block does and apply an insert to the private copy.
    function automatic answer_t probe_table(logic rtype, key_t k, logic [PLD_W-1:0] p);
        answer_t a;
        idx_t    i;
        i        = idx_t'($unsigned(k) % TABLE_DEPTH);
        a.pld    = '0;
        a.slot   = '0;
        if (rtype == REQ_INSERT) begin
            a.status = ST_FULL;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                if (!slot_used[i]) begin
                    slot_used[i] = 1'b1;
                    slot_keys[i] = k;
                    slot_plds[i] = slot_pld_t'(p);
                    a.status     = ST_INSERTED;
                    a.slot       = SLOT_OUT_W'(i);
                    break;
                end
                i = (i == idx_t'(TABLE_DEPTH - 1)) ? '0 : i + 1'b1;
            end
        end
        else begin
            a.status = ST_NOT_FOUND;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                if (!slot_used[i])
                    break;
                if (slot_keys[i] == k) begin
                    a.status = ST_FOUND;
                    a.pld    = PLD_W'(slot_plds[i]);
                    a.slot   = SLOT_OUT_W'(i);
                    break;
                end
                i = (i == idx_t'(TABLE_DEPTH - 1)) ? '0 : i + 1'b1;
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        answer_t due;
        if (!rst_n) begin
            foreach (slot_used[j])
                slot_used[j] = 1'b0;
            answers_due.delete();
            n_fail    = 0;
            n_pending = 0;
            n_hits    = 0;
            n_full    = 0;
        end
        else begin
            // Retire the response first: it always belongs to an earlier request.
            if (rsp.valid && rsp.ready) begin
                if (answers_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: response with nothing outstanding: status %0d payload %h slot %0d",
                                 $realtime, rsp.status, rsp.found_payload, rsp.slot_index);
                end
                else begin
                    due = answers_due.pop_front();
                    if (rsp.status !== due.status || rsp.found_payload !== due.pld
                        || rsp.slot_index !== due.slot) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("%0t: mismatch: expected %s payload %h slot %0d, got status %0d payload %h slot %0d",
                                     $realtime, due.status.name(), due.pld, due.slot,
                                     rsp.status, rsp.found_payload, rsp.slot_index);
                    end
                end
            end
            if (req.valid && req.ready) begin
                due = probe_table(req.req_type, req.key, req.payload);
                answers_due.push_back(due);
                if (due.status == ST_FOUND)
                    n_hits++;
                if (due.status == ST_FULL)
                    n_full++;
            end
            n_pending = answers_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for linear_probe_hash_table: clock, reset, request and response traffic
// and the verdict. Depends on lpht_pkg, lpht_ifs, the block itself and lpht_checker.
`timescale 1ns / 1ps

module tb_top;
    import lpht_pkg::*;

    localparam int RAND_ITEMS = 700;

    logic clk;
    logic rst_n;
    int   n_fail;
    int   n_pending;
    int   n_hits;
    int   n_full;
    int   n_inserts;
    int   n_lookups;
    key_t stored_keys [$];

    lpht_req_if req_if ();
    lpht_rsp_if rsp_if ();

    linear_probe_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    lpht_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .n_fail    (n_fail),
        .n_pending (n_pending),
        .n_hits    (n_hits),
        .n_full    (n_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Keys crowd around a few home slots, both ends of the table among them, so that
    // probe chains grow long and wrap.
    function automatic key_t fresh_key();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 3))
            0:       r[7:0] = 8'($urandom_range(0, 7));
            1:       r[7:0] = 8'($urandom_range(248, 255));
            default: r[7:0] = 8'($urandom_range(0, 255));
        endcase
        return key_t'(r);
    endfunction

    function automatic key_t known_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Offer one transaction at the falling edge and hold it until it is taken.
    task automatic send_req(input logic rtype, input key_t k, input logic [PLD_W-1:0] p);
        int gap;
        gap = ((n_inserts + n_lookups) / 100 % 4 == 3) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rtype;
        req_if.key      <= k;
        req_if.payload  <= p;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (rtype == REQ_INSERT) begin
            n_inserts++;
            stored_keys.push_back(k);
        end
        else
            n_lookups++;
        @(negedge clk);
    endtask

    // Response side: random stalls, bursts with none, and one long hold-off that
    // backs the block up into its request port.
    initial
    begin : drain
        int taken;
        int stall;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (taken == 150)
                stall = 400;
            else if (taken / 80 % 4 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            taken++;
        end
    end

    initial
    begin
        key_t k;
        n_inserts       = 0;
        n_lookups       = 0;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_INSERT;
        req_if.key      = '0;
        req_if.payload  = '0;
        rsp_if.ready    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, wrap-around from the top slot, a duplicate key and misses.
        send_req(REQ_INSERT, 32'sh0000_0000, 16'h0000);
        send_req(REQ_INSERT, 32'shFFFF_FFFF, 16'hFFFF);
        send_req(REQ_INSERT, 32'sh7FFF_FFFF, 16'h8001);
        send_req(REQ_INSERT, 32'sh8000_0000, 16'h7FFE);
        send_req(REQ_INSERT, 32'sh0000_0000, 16'h1234);
        send_req(REQ_LOOKUP, 32'sh0000_0000, 16'h0000);
        send_req(REQ_LOOKUP, 32'shFFFF_FFFF, 16'h0000);
        send_req(REQ_LOOKUP, 32'sh7FFF_FFFF, 16'hFFFF);
        send_req(REQ_LOOKUP, 32'sh8000_0000, 16'h5A5A);
        send_req(REQ_LOOKUP, 32'sh0000_0100, 16'h0000);
        send_req(REQ_LOOKUP, 32'sh0000_0010, 16'h0000);
        send_req(REQ_LOOKUP, 32'shFFFF_FEFF, 16'h0000);
        send_req(REQ_INSERT, 32'sh5555_AAAA, 16'hAAAA);
        send_req(REQ_LOOKUP, 32'sh5555_AAAA, 16'h5555);

        // Roughly two inserts in five: the table fills late in the run, after which
        // inserts are refused and misses probe every slot.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 40) begin
                k = (stored_keys.size() > 0 && $urandom_range(0, 6) == 0)
                    ? known_key() : fresh_key();
                send_req(REQ_INSERT, k, 16'($urandom_range(0, 65535)));
            end
            else begin
                k = (stored_keys.size() > 0 && $urandom_range(0, 9) < 6)
                    ? known_key() : fresh_key();
                send_req(REQ_LOOKUP, k, 16'($urandom_range(0, 65535)));
            end
        end
        req_if.valid <= 1'b0;

        while (n_pending != 0)
            @(posedge clk);
        // Let any stray response surface.
        repeat (TABLE_DEPTH + 40) @(posedge clk);

        $display("Run covered %0d inserts (%0d refused on a full table)",
                 n_inserts, n_full);
        $display("and %0d lookups (%0d hits), with clustered and wrapping probe chains,",
                 n_lookups, n_hits);
        $display("duplicates and a long response stall.");
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: fails the run if it has not finished by then.
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
